// ===== rtl/parity_crc_frame_serializer_core_assert.svh =====
// Assertion macros shared by the serializer RTL.
`ifndef PARITY_CRC_FRAME_SERIALIZER_CORE_ASSERT_SVH
`define PARITY_CRC_FRAME_SERIALIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PCFS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("serializer check failed in the same cycle");
`define PCFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("serializer check failed one cycle later");
`else
`define PCFS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PCFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/pcfs_pkg.sv =====
// Types, constants and the CRC byte update for the parity/CRC frame serializer.
package pcfs_pkg;

    localparam int CharW      = 7;
    localparam int ByteBits   = 8;
    localparam int CrcW       = 16;
    localparam int FrameBits  = ByteBits + CrcW;
    localparam int LeftW      = $clog2(FrameBits + 1);
    localparam int QueueDepth = 2;
    localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW       = $clog2(QueueDepth + 1);

    localparam logic [CrcW-1:0] CrcInitial  = 16'h0000;
    localparam logic [CrcW-1:0] CrcPolyInit = 16'h8005;

    typedef enum logic [0:0] {
        REG_PARITY_ODD = 1'b0,
        REG_CRC_POLY   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CharW-1:0] char_value;
        logic             in_payload;
        logic             end_of_frame;
    } char_item_t;

    typedef struct packed {
        logic line_bit;
        logic last_of_run;
    } bit_item_t;

    // One queued job: the framed byte, and the CRC to send after it if any.
    typedef struct packed {
        logic                send_crc;
        logic [CrcW-1:0]     crc;
        logic [ByteBits-1:0] frame_byte;
    } job_t;

    typedef struct packed {
        logic            valid;
        job_t            job;
        logic [CntW-1:0] count;
    } queue_status_t;

    typedef struct packed {
        logic busy;
    } back_status_t;

    // MSB-first CRC update over one byte, no reflection.
    function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0]     r,
                                                 input logic [ByteBits-1:0] b,
                                                 input logic [CrcW-1:0]     poly);
        logic [CrcW-1:0] v;
        v = r ^ {b, {(CrcW-ByteBits){1'b0}}};
        for (int k = 0; k < ByteBits; k++)
        begin
            if (v[CrcW-1])
                v = (v << 1) ^ poly;
            else
                v = v << 1;
        end
        return v;
    endfunction

endpackage

// ===== rtl/pcfs_front.sv =====
// Front end: configuration registers, parity insertion and the running CRC.
module pcfs_front
    import pcfs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [CrcW-1:0]     cfg_data,
    input  logic                char_valid,
    input  logic                char_stall,
    input  char_item_t          char_item,
    output logic                push_valid,
    output job_t                push_job
);

    logic            parity_odd_reg;
    logic [CrcW-1:0] crc_poly_reg;
    logic [CrcW-1:0] crc_reg;
    logic [CrcW-1:0] crc_next;
    logic [CrcW-1:0] crc_fed;
    logic            set_bit;
    logic [ByteBits-1:0] frame_byte;
    logic            accept;
    logic            send_crc;

    assign accept     = char_valid && !char_stall;
    // Odd sense sets bit 7 when the seven character bits hold an even count of ones.
    assign set_bit    = parity_odd_reg ? ~(^char_item.char_value) : (^char_item.char_value);
    assign frame_byte = {set_bit, char_item.char_value};
    assign crc_fed    = crc_feed(crc_reg, frame_byte, crc_poly_reg);
    assign send_crc   = char_item.in_payload && char_item.end_of_frame;

    always_comb
    begin
        crc_next = crc_reg;
        if (accept && char_item.in_payload)
            crc_next = send_crc ? CrcInitial : crc_fed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_odd_reg <= 1'b1;
            crc_poly_reg   <= CrcPolyInit;
            crc_reg        <= CrcInitial;
        end
        else
        begin
            crc_reg <= crc_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_PARITY_ODD: parity_odd_reg <= cfg_data[0];
                    REG_CRC_POLY:   crc_poly_reg   <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    assign push_valid          = char_valid;
    assign push_job.send_crc   = send_crc;
    assign push_job.crc        = crc_fed;
    assign push_job.frame_byte = frame_byte;

endmodule

// ===== rtl/pcfs_queue.sv =====
// Short job queue between the front end and the bit serializer.
module pcfs_queue
    import pcfs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  job_t          push_job,
    output logic          full,
    input  logic          pop,
    output queue_status_t status
);

    job_t            entry_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CntW'(QueueDepth));
    assign do_push = push_valid && !full;
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    assign status.valid = (count_reg != '0);
    assign status.job   = entry_reg[rd_ptr_reg];
    assign status.count = count_reg;

endmodule

// ===== rtl/pcfs_back.sv =====
// Back end: shifts jobs out one bit per cycle unless stalled, via an output register.
module pcfs_back
    import pcfs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t queue,
    output logic          pop,
    output logic          bit_valid,
    input  logic          bit_stall,
    output bit_item_t     bit_item,
    output back_status_t  status
);

    logic [FrameBits-1:0] sh_reg;
    logic [FrameBits-1:0] sh_next;
    logic [LeftW-1:0]     left_reg;
    logic [LeftW-1:0]     left_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    bit_item_t            out_item_reg;
    bit_item_t            out_item_next;
    logic                 out_free;
    logic                 emit;
    logic                 refill;

    assign out_free = !out_valid_reg || !bit_stall;
    assign emit     = out_free && (left_reg != '0);
    // A new job loads as the previous one hands off its final bit, so runs stay gapless.
    assign refill   = queue.valid && ((left_reg == '0) || ((left_reg == LeftW'(1)) && emit));
    assign pop      = refill;

    always_comb
    begin
        sh_next   = sh_reg;
        left_next = left_reg;
        if (emit)
        begin
            sh_next   = sh_reg >> 1;
            left_next = left_reg - 1'b1;
        end
        if (refill)
        begin
            // Byte first, then the CRC high byte, then the low byte, each LSB first.
            sh_next   = {queue.job.crc[ByteBits-1:0], queue.job.crc[CrcW-1:ByteBits],
                         queue.job.frame_byte};
            left_next = queue.job.send_crc ? LeftW'(FrameBits) : LeftW'(ByteBits);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (emit)
        begin
            out_valid_next            = 1'b1;
            out_item_next.line_bit    = sh_reg[0];
            out_item_next.last_of_run = (left_reg == LeftW'(1));
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg       <= sh_next;
        out_item_reg <= out_item_next;
    end

    assign bit_valid   = out_valid_reg;
    assign bit_item    = out_item_reg;
    assign status.busy = (left_reg != '0);

endmodule

// ===== rtl/parity_crc_frame_serializer_core.sv =====
// Top level of the parity/CRC frame serializer.
//
// Characters arrive on the char channel (char_valid, char_stall, char_item); a transfer
// happens on a clock edge with char_valid high and char_stall low. Each character gets
// its parity bit in bit 7 and leaves as eight line bits on the bit channel, LSB first.
// A payload character marked end of frame is followed by the 16 CRC bits, high byte
// first, so it produces 24 bits; last_of_run marks the final bit of each character.
// The first bit passes from the queue entry through the shifter to the output register
// when the back end is idle. The line runs at one bit per cycle while bit_stall is low;
// the bit-serial output register sets that rate. A two-entry job queue lets the
// next character be taken while the current one is still shifting out.
// cfg_we writes register cfg_index (0 parity sense, 1 CRC polynomial) from cfg_data.
// Reset sets odd parity, polynomial 0x8005 and a zero CRC, and empties the queue.
// When the receiver holds bit_stall, the current bit stays on the port, the shifter
// pauses, and char_stall rises once the queue is full.
`include "parity_crc_frame_serializer_core_assert.svh"

module parity_crc_frame_serializer_core
    import pcfs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_index,
    input  logic [CrcW-1:0] cfg_data,
    input  logic            char_valid,
    output logic            char_stall,
    input  char_item_t      char_item,
    output logic            bit_valid,
    input  logic            bit_stall,
    output bit_item_t       bit_item
);

    logic          push_valid;
    job_t          push_job;
    logic          q_full;
    logic          pop;
    queue_status_t q_status;
    back_status_t  b_status;
    logic          char_xfer;
    logic          last_bit_idle;

    assign char_stall = q_full;
    assign char_xfer  = char_valid && !char_stall;

    // Final bit of a run leaves with nothing queued, shifting or arriving behind it.
    assign last_bit_idle = bit_valid && !bit_stall && bit_item.last_of_run &&
                           !q_status.valid && !b_status.busy && !char_xfer;

    pcfs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    pcfs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .status     (q_status)
    );

    pcfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .queue     (q_status),
        .pop       (pop),
        .bit_valid (bit_valid),
        .bit_stall (bit_stall),
        .bit_item  (bit_item),
        .status    (b_status)
    );

    // The queue never holds more jobs than it has entries.
    `PCFS_ASSERT_IMPLIES(a_queue_bound, clk, rst_n, 1'b1, q_status.count <= CntW'(QueueDepth))
    // A character transfer always leaves a job in the queue.
    `PCFS_ASSERT_NEXT(a_accept_queued, clk, rst_n, char_xfer, q_status.count != '0)
    // With nothing queued or shifting, the final bit transfer leaves the line idle.
    `PCFS_ASSERT_NEXT(a_idle_after_last, clk, rst_n, last_bit_idle, !bit_valid)

endmodule
